>>> hdl/imm_pkg.sv
// Shared types and constants for the image min/max/mean statistics block.
// No dependencies; imported by every module of the block.
package imm_pkg;

   localparam int PIXEL_W      = 8;
   localparam int CFG_W        = 13;
   localparam int RESULT_W     = 3 * PIXEL_W;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   localparam logic [CFG_W-1:0]   WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0]   HEIGHT_RESET = CFG_W'(480);
   localparam logic [PIXEL_W-1:0] PIXEL_MAX    = '1;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // One pixel on its way from the front end to the back end.
   typedef struct packed {
      logic               last;
      logic [PIXEL_W-1:0] pixel;
   } imm_entry_type;

   // One finished frame result.
   typedef struct packed {
      logic [PIXEL_W-1:0] average_value;
      logic [PIXEL_W-1:0] max_value;
      logic [PIXEL_W-1:0] min_value;
   } imm_result_type;

   typedef enum logic [3:0] {
      DIV_IDLE = 4'b0001,
      DIV_PREP = 4'b0010,
      DIV_RUN  = 4'b0100,
      DIV_HOLD = 4'b1000
   } div_state_type;

endpackage

>>> hdl/imm_front.sv
// Front end: frame size registers, input stage and end-of-frame tagging.
// Depends on imm_pkg.
module imm_front import imm_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [0:0]          csr_index,
   input  logic [CFG_W-1:0]    csr_wdata,
   input  logic                pix_valid,
   output logic                pix_ready,
   input  logic [PIXEL_W-1:0]  pix_data,
   output logic                push_valid,
   output imm_entry_type       push_entry,
   input  logic                push_full
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CNT_W = 2 * DIM_W;

   logic [CFG_W-1:0]   width_ff, height_ff;
   logic [DIM_W-1:0]   width_eff, height_eff;
   logic [CNT_W-1:0]   size_ff;
   logic               stage_valid_ff, stage_valid_in;
   logic [PIXEL_W-1:0] stage_pixel_ff;
   logic [CNT_W-1:0]   count_ff, count_in, count_next;
   logic               is_last, push_fire;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      if (wide == 32'd0)                 return DIM_W'(1);
      else if (wide > 32'(MAX_DIM))      return DIM_W'(MAX_DIM);
      else                               return DIM_W'(wide);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Registered product; a pixel is tagged while it sits in the input stage register.
   assign width_eff  = eff_dim(width_ff);
   assign height_eff = eff_dim(height_ff);

   always_ff @(posedge clock) begin
      size_ff <= CNT_W'(width_eff) * CNT_W'(height_eff);
   end

   assign push_fire  = stage_valid_ff && !push_full;
   assign pix_ready  = !stage_valid_ff || !push_full;
   assign count_next = count_ff + CNT_W'(1);
   assign is_last    = (count_next >= size_ff);

   assign push_valid       = stage_valid_ff;
   assign push_entry.pixel = stage_pixel_ff;
   assign push_entry.last  = is_last;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (pix_valid && pix_ready) stage_valid_in = 1'b1;
      else if (push_fire)         stage_valid_in = 1'b0;
      count_in = count_ff;
      if (push_fire) count_in = is_last ? '0 : count_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         count_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_valid && pix_ready) stage_pixel_ff <= pix_data;
   end

endmodule

>>> hdl/imm_queue.sv
// Short queue of tagged pixels between the front end and the back end.
// Depends on imm_pkg.
module imm_queue import imm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  imm_entry_type push_entry,
   output logic          full,
   output logic          head_valid,
   output imm_entry_type head_entry,
   input  logic          pop
);

   imm_entry_type       slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     fill_ff, fill_in;
   logic                do_push, do_pop;

   assign full       = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop)      fill_in = fill_ff + (QPTR_W+1)'(1);
      else if (do_pop && !do_push) fill_in = fill_ff - (QPTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

>>> hdl/imm_back.sv
// Back end: running min/max/sum/count, per-frame mean divider, result register.
// Depends on imm_pkg.
module imm_back import imm_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  imm_entry_type  head_entry,
   output logic           pop,
   output logic           out_valid,
   input  logic           out_ready,
   output imm_result_type out_result
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CNT_W = 2 * DIM_W;
   localparam int SUM_W = CNT_W + PIXEL_W;
   localparam int NUM_W = SUM_W + 1;

   logic [PIXEL_W-1:0] min_ff, max_ff, min_next, max_next;
   logic [SUM_W-1:0]   sum_ff, sum_next;
   logic [CNT_W-1:0]   cnt_ff, cnt_next;

   div_state_type      state_ff, state_in;
   logic [SUM_W-1:0]   fin_sum_ff;
   logic [CNT_W-1:0]   fin_cnt_ff;
   logic [PIXEL_W-1:0] fin_min_ff, fin_max_ff;
   logic [NUM_W-1:0]   rem_ff, dsh_ff, rem_diff;
   logic [PIXEL_W-1:0] quo_ff;
   logic [2:0]         step_ff;
   logic               rem_ge, out_free, load_out;
   logic               out_valid_ff, out_valid_in;
   imm_result_type     out_ff;

   assign pop = head_valid && (!head_entry.last || state_ff == DIV_IDLE);

   assign min_next = (head_entry.pixel < min_ff) ? head_entry.pixel : min_ff;
   assign max_next = (head_entry.pixel > max_ff) ? head_entry.pixel : max_ff;
   assign sum_next = sum_ff + SUM_W'(head_entry.pixel);
   assign cnt_next = cnt_ff + CNT_W'(1);

   // Accumulate; clear on the frame's final pixel.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= PIXEL_MAX;
         max_ff <= '0;
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (pop) begin
         if (head_entry.last) begin
            min_ff <= PIXEL_MAX;
            max_ff <= '0;
            sum_ff <= '0;
            cnt_ff <= '0;
         end else begin
            min_ff <= min_next;
            max_ff <= max_next;
            sum_ff <= sum_next;
            cnt_ff <= cnt_next;
         end
      end
   end

   assign rem_diff = rem_ff - dsh_ff;
   assign rem_ge   = (rem_ff >= dsh_ff);
   assign out_free = !out_valid_ff || out_ready;
   assign load_out = (state_ff == DIV_HOLD) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: if (pop && head_entry.last) state_in = DIV_PREP;
         DIV_PREP: state_in = DIV_RUN;
         DIV_RUN:  if (step_ff == 3'd0) state_in = DIV_HOLD;
         DIV_HOLD: if (out_free) state_in = DIV_IDLE;
         default:  state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= DIV_IDLE;
      else       state_ff <= state_in;
   end

   // Restoring divide, one quotient bit per cycle, most significant first.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         DIV_IDLE: begin
            if (pop && head_entry.last) begin
               fin_sum_ff <= sum_next;
               fin_cnt_ff <= cnt_next;
               fin_min_ff <= min_next;
               fin_max_ff <= max_next;
            end
         end
         DIV_PREP: begin
            rem_ff  <= NUM_W'(fin_sum_ff) + NUM_W'(fin_cnt_ff >> 1);
            dsh_ff  <= NUM_W'({fin_cnt_ff, 7'd0});
            quo_ff  <= '0;
            step_ff <= 3'd7;
         end
         DIV_RUN: begin
            if (rem_ge) rem_ff <= rem_diff;
            quo_ff  <= {quo_ff[PIXEL_W-2:0], rem_ge};
            dsh_ff  <= dsh_ff >> 1;
            step_ff <= step_ff - 3'd1;
         end
         DIV_HOLD: ;
         default: ;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out)       out_valid_in = 1'b1;
      else if (out_ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff.min_value     <= fin_min_ff;
         out_ff.max_value     <= fin_max_ff;
         out_ff.average_value <= quo_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule

>>> hdl/image_min_max_mean.sv
// A frame's result reaches rsp_ from the transaction carrying its last pixel
// through the input stage, the queue, the divider set-up and 8 divide steps.
// Throughput: one pixel per cycle while the queue has room; the bit-serial
// mean divider runs per frame, so a frame end waits while the previous one divides.
// Reset (synchronous, active high) sets frame 640 x 480 and clears all counts.
module image_min_max_mean import imm_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   // Pixel input channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [PIXEL_W-1:0]   req_tdata,   // [7:0] pixel
   // Result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RESULT_W-1:0]  rsp_tdata,   // [7:0] min_value, [15:8] max_value,
                                             // [23:16] average_value
   // Register write port
   input  logic                 csr_we,
   input  logic [0:0]           csr_index,   // 0 frame_width, 1 frame_height
   input  logic [CFG_W-1:0]     csr_wdata
);

   logic           push_valid, push_full;
   imm_entry_type  push_entry;
   logic           head_valid, pop;
   imm_entry_type  head_entry;
   imm_result_type result;

   // Front: accept pixels and tag the one that closes the frame.
   imm_front #(.MAX_DIM(MAX_DIM)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pix_valid  (req_tvalid),
      .pix_ready  (req_tready),
      .pix_data   (req_tdata),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_full  (push_full)
   );

   // Queue: lets the front keep accepting while the back divides.
   imm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (push_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   // Back: accumulate, divide once per frame, hold the result until taken.
   imm_back #(.MAX_DIM(MAX_DIM)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = result;

endmodule

>>> hdl/imm_checker.sv
// Port-level checks for the image statistics block, bound to its top level.
// Depends on imm_pkg.
module imm_checker import imm_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RESULT_W-1:0] rsp_tdata
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_mean_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] <= rsp_tdata[15:8]) &&
                     (rsp_tdata[23:16] >= rsp_tdata[7:0]) &&
                     (rsp_tdata[23:16] <= rsp_tdata[15:8]))
      else $error("mean outside min..max");

endmodule

bind image_min_max_mean imm_checker u_imm_checker (.*);

>>> tb/image_min_max_mean_tb.sv
// Self-checking testbench for image_min_max_mean: streams pixels into the block and
// checks each frame's min, max and rounded mean against an in-bench prediction.
// Depends on imm_pkg and the image_min_max_mean RTL only.
module image_min_max_mean_tb;
   import imm_pkg::*;

   localparam int MAX_DIM        = 4096;
   localparam int RANDOM_ITEMS   = 1800;
   localparam int MAX_RUN        = 150;   // longest random run of pixels
   localparam int IDLE_PCT       = 36;
   localparam int SETTLE_CYCLES  = 32;
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction

   typedef enum int {
      SPREAD_FULL,
      SPREAD_LOW,
      SPREAD_HIGH,
      SPREAD_FLAT
   } pixel_spread_type;

   // Frame statistics predictor plus the queue of frame results still owed by the block.
   class frame_stats_board;
      bit [CFG_W-1:0]   frame_width;
      bit [CFG_W-1:0]   frame_height;
      bit [PIXEL_W-1:0] run_min;
      bit [PIXEL_W-1:0] run_max;
      bit [31:0]        run_sum;
      bit [24:0]        run_count;
      imm_result_type   owed_frames[$];
      int               errors;

      function new();
         frame_width  = WIDTH_RESET;
         frame_height = HEIGHT_RESET;
         errors       = 0;
         clear_running();
      endfunction

      function void clear_running();
         run_min   = PIXEL_MAX;
         run_max   = '0;
         run_sum   = '0;
         run_count = '0;
      endfunction

      // Zero counts as one, anything past MAX_DIM saturates.
      function longint unsigned span(bit [CFG_W-1:0] v);
         if (v == 0) begin
            return 1;
         end
         if (v > MAX_DIM) begin
            return MAX_DIM;
         end
         return longint'(v);
      endfunction

      function void write_reg(csr_index_type idx, bit [CFG_W-1:0] v);
         case (idx)
            CSR_FRAME_WIDTH:  frame_width  = v;
            CSR_FRAME_HEIGHT: frame_height = v;
            default: ;
         endcase
      endfunction

      function void note_pixel(bit [PIXEL_W-1:0] p);
         longint unsigned frame_size;
         longint unsigned mean;
         imm_result_type  done;
         frame_size = span(frame_width) * span(frame_height);
         if (p < run_min) begin
            run_min = p;
         end
         if (p > run_max) begin
            run_max = p;
         end
         run_sum   = run_sum + 32'(p);
         run_count = run_count + 25'd1;
         if (run_count >= frame_size) begin
            mean = (longint'(run_sum) + (run_count >> 1)) / run_count;
            if (mean > PIXEL_MAX) begin
               mean = PIXEL_MAX;
            end
            done.min_value     = run_min;
            done.max_value     = run_max;
            done.average_value = mean[PIXEL_W-1:0];
            owed_frames.push_back(done);
            clear_running();
         end
      endfunction

      function void check_result(imm_result_type got);
         imm_result_type want;
         if (owed_frames.size() == 0) begin
            $display("%0t: unexpected result min %0d max %0d mean %0d", $time,
                     got.min_value, got.max_value, got.average_value);
            errors++;
            return;
         end
         want = owed_frames.pop_front();
         if (got.min_value !== want.min_value) begin
            $display("%0t: min_value expected %0d actual %0d", $time,
                     want.min_value, got.min_value);
            errors++;
         end
         if (got.max_value !== want.max_value) begin
            $display("%0t: max_value expected %0d actual %0d", $time,
                     want.max_value, got.max_value);
            errors++;
         end
         if (got.average_value !== want.average_value) begin
            $display("%0t: average_value expected %0d actual %0d", $time,
                     want.average_value, got.average_value);
            errors++;
         end
      endfunction

      function int pending();
         return owed_frames.size();
      endfunction
   endclass

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [PIXEL_W-1:0]  req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RESULT_W-1:0] rsp_tdata;
   logic                csr_we     = 1'b0;
   logic [0:0]          csr_index  = CSR_FRAME_WIDTH;
   logic [CFG_W-1:0]    csr_wdata  = '0;

   frame_stats_board sb;
   bit               steady       = 1'b0;  // both sides stop idling while set
   bit               hold_off_req = 1'b0;  // ask the receiver for its one long hold-off
   bit               hold_done    = 1'b0;
   int               stall_left   = 0;
   int               sent         = 0;

   always #1 clock = ~clock;

   image_min_max_mean #(.MAX_DIM(MAX_DIM)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Observe every transaction at the clock edge it completes on. All inputs change
   // through nonblocking assignments, so the values read here are the ones the block saw.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            sb.write_reg(csr_index_type'(csr_index), csr_wdata);
         end
         if (req_tvalid && req_tready) begin
            sb.note_pixel(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(imm_result_type'(rsp_tdata));
         end
      end
   end

   // Result receiver: random back-pressure, one long hold-off on request, none while steady.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (hold_off_req && !hold_done) begin
         rsp_tready <= 1'b0;
         stall_left <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("image_min_max_mean_tb: FAIL");
      $finish;
   end

   // Offer one pixel, idling at random first; return at the edge that accepts it.
   // Valid stays high across back-to-back pixels, so it is assigned once per step.
   task automatic send_pixel(input bit [PIXEL_W-1:0] p);
      while (!steady && ($urandom_range(99) < IDLE_PCT)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   task automatic send_run(input int count, input pixel_spread_type spread);
      bit [PIXEL_W-1:0] level;
      bit [PIXEL_W-1:0] p;
      level = PIXEL_W'($urandom_range(255));
      repeat (count) begin
         case (spread)
            SPREAD_LOW:  p = PIXEL_W'($urandom_range(3));
            SPREAD_HIGH: p = PIXEL_W'($urandom_range(255, 252));
            SPREAD_FLAT: p = level;
            default:     p = PIXEL_W'($urandom_range(255));
         endcase
         send_pixel(p);
         sent++;
      end
   endtask

   // Drop valid, wait for every owed result, then let any partial frame settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input bit [CFG_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Registers change only with the block drained.
   task automatic set_frame(input bit [CFG_W-1:0] w, input bit [CFG_W-1:0] h);
      wait_idle();
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
   endtask

   initial begin
      bit [PIXEL_W-1:0] lead_in [5];
      bit [PIXEL_W-1:0] singles [4];
      bit [PIXEL_W-1:0] halves  [6];
      bit [PIXEL_W-1:0] partial [4];
      bit [CFG_W-1:0]   w;
      bit [CFG_W-1:0]   h;
      int               phase;
      int               frame_size;
      int               run_len;
      int               r;

      lead_in = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254};
      singles = '{8'd77, 8'd0, 8'd255, 8'd170};
      halves  = '{8'd0, 8'd1, 8'd254, 8'd255, 8'd100, 8'd101};
      partial = '{8'd9, 8'd200, 8'd50, 8'd3};

      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: start a frame at the reset size (640 x 480) and leave it unfinished.
      foreach (lead_in[i]) send_pixel(lead_in[i]);

      // Zero width and height both mean one. The carried-over pixels are already past
      // the new size, so the next pixel closes that frame; the rest are 1-pixel frames.
      set_frame('0, '0);
      foreach (singles[i]) send_pixel(singles[i]);

      // Two-pixel frames: exact halves must round up.
      set_frame(2, 1);
      foreach (halves[i]) send_pixel(halves[i]);

      // Shrink the frame mid-way: four of six pixels in, the size drops to two, so the
      // fifth pixel ends the frame and the mean divides by five.
      set_frame(3, 2);
      foreach (partial[i]) send_pixel(partial[i]);
      set_frame(2, 1);
      send_pixel(8'd60);

      // Random phases: small frames, random pixel counts so frames often straddle
      // a size change, and pixel spreads that push min, max and the mean to the rails.
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         r = $urandom_range(19);
         w = (r == 0) ? '0 : (r == 1) ? CFG_W'($urandom_range(64, 13))
                                      : CFG_W'($urandom_range(12, 1));
         r = $urandom_range(19);
         h = (r == 0) ? '0 : CFG_W'($urandom_range(6, 1));
         frame_size = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);

         if (phase == 4) begin
            // No idling on either side for a long stretch.
            set_frame(5, 3);
            steady = 1'b1;
            send_run(300, SPREAD_FULL);
            steady = 1'b0;
         end else if (phase == 8) begin
            // One-pixel frames while the receiver holds off: the result stays held, the pixel
            // queue fills and the block has to stall its pixel input.
            set_frame(1, 1);
            hold_off_req = 1'b1;
            send_run(60, SPREAD_FULL);
         end else begin
            set_frame(w, h);
            run_len = $urandom_range(3 * frame_size + 2, 1);
            if (run_len > MAX_RUN) begin
               run_len = MAX_RUN;
            end
            if (run_len > RANDOM_ITEMS - sent) begin
               run_len = RANDOM_ITEMS - sent;
            end
            send_run(run_len, pixel_spread_type'($urandom_range(3)));
         end
         phase++;
      end

      // Oversized sizes: width past MAX_DIM saturates and height at MAX_DIM, so short
      // runs must not close the frame; a small size then closes it on the next pixel.
      set_frame('1, '0);
      send_run(40, SPREAD_FULL);
      set_frame(1, CFG_W'(MAX_DIM));
      send_run(40, SPREAD_HIGH);
      set_frame(4, 1);
      send_run(1, SPREAD_LOW);

      wait_idle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("image_min_max_mean_tb: PASS");
      end else begin
         $display("image_min_max_mean_tb: FAIL");
      end
      $finish;
   end

endmodule

>>> image_min_max_mean.f
hdl/imm_pkg.sv
hdl/imm_front.sv
hdl/imm_queue.sv
hdl/imm_back.sv
hdl/image_min_max_mean.sv
hdl/imm_checker.sv
tb/image_min_max_mean_tb.sv
